// ===== hw/rtl/lru_key_value_cache_core_defines.svh =====
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// concurrent checks for the cache rtl, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define LKC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LKC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LKC_ASSERT(lbl, clk, rst_n, prop, msg)

`define LKC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/lru_kvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache package
// word types and fixed constants shared by the cache rtl
// ----------------------------------------------------------------------------
package lru_kvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kinds
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [KEY_W-1:0]   lookup_key;
        logic signed [VALUE_W-1:0] write_value;
    } req_word_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
    } rsp_word_t;

endpackage

// ===== hw/rtl/lru_kvc_match.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache key match
// parallel key compare over all entries, first match wins
// ----------------------------------------------------------------------------
module lru_kvc_match #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]                   valid,
    input  logic [lru_kvc_pkg::KEY_W-1:0]      keys   [DEPTH],
    input  logic [lru_kvc_pkg::VALUE_W-1:0]    values [DEPTH],
    input  logic [lru_kvc_pkg::KEY_W-1:0]      key,
    output logic                               hit,
    output logic [DEPTH-1:0]                   sel,
    output logic [lru_kvc_pkg::VALUE_W-1:0]    value
);
    import lru_kvc_pkg::*;

    always_comb
    begin
        hit   = 1'b0;
        sel   = '0;
        value = '1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!hit && valid[i] && (keys[i] == key))
            begin
                hit    = 1'b1;
                sel[i] = 1'b1;
                value  = values[i];
            end
        end
    end

endmodule

// ===== hw/rtl/lru_kvc_table.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache table
// entry storage, recency ranks and the one-pass get/put update
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_defines.svh"

module lru_kvc_table #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  lru_kvc_pkg::req_word_t        op,
    input  logic [lru_kvc_pkg::CAP_W-1:0] capacity,
    output lru_kvc_pkg::rsp_word_t        result
);
    import lru_kvc_pkg::*;

    localparam int RANK_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(DEPTH - 1);

    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg  [DEPTH];
    logic [RANK_W-1:0]  rank_next [DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg   [DEPTH];
    logic [VALUE_W-1:0] value_reg [DEPTH];

    logic               match_hit;
    logic [DEPTH-1:0]   match_sel;
    logic [VALUE_W-1:0] match_value;

    logic [DEPTH-1:0]   key_we, value_we;

    // intermediate views of the miss path: after full eviction, insert, trim
    logic [DEPTH-1:0]   valid_a, valid_b, ins_sel;
    logic [RANK_W-1:0]  rank_a [DEPTH];
    logic [RANK_W-1:0]  rank_b [DEPTH];
    logic [CNT_W-1:0]   count_a, count_b;
    logic [RANK_W-1:0]  hit_rank;
    logic               full, over, free_found;

    lru_kvc_match #(
        .DEPTH (DEPTH)
    ) u_match (
        .valid  (valid_reg),
        .keys   (key_reg),
        .values (value_reg),
        .key    (op.lookup_key),
        .hit    (match_hit),
        .sel    (match_sel),
        .value  (match_value)
    );

    assign result.hit        = match_hit;
    assign result.read_value = (match_hit && (op.action == ACT_GET)) ? match_value : '1;

    always_comb
    begin
        hit_rank = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_sel[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
            end
        end
    end

    // miss path: free a slot when full, insert as most recent, trim to capacity
    always_comb
    begin
        full    = (count_reg == CNT_FULL);
        valid_a = valid_reg;
        count_a = count_reg - CNT_W'(full);
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_a[i] = rank_reg[i];
            if (full && valid_reg[i] && (rank_reg[i] == RANK_LAST))
            begin
                valid_a[i] = 1'b0;
                rank_a[i]  = '0;
            end
        end

        free_found = 1'b0;
        ins_sel    = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!free_found && !valid_a[i])
            begin
                free_found = 1'b1;
                ins_sel[i] = 1'b1;
            end
        end

        valid_b = valid_a | ins_sel;
        count_b = count_a + CNT_W'(free_found);
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_b[i] = valid_a[i] ? (rank_a[i] + 1'b1) : rank_a[i];
            if (ins_sel[i])
            begin
                rank_b[i] = '0;
            end
        end

        over = (CMP_W'(count_b) > CMP_W'(capacity));
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        key_we     = '0;
        value_we   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (op_valid && match_hit)
        begin
            // move the hit entry to the front, younger entries age by one
            for (int i = 0; i < DEPTH; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
                if (match_sel[i])
                begin
                    rank_next[i] = '0;
                end
            end
            if (op.action == ACT_PUT)
            begin
                value_we = match_sel;
            end
        end
        else if (op_valid && (op.action == ACT_PUT) && free_found)
        begin
            key_we     = ins_sel;
            value_we   = ins_sel;
            valid_next = valid_b;
            count_next = count_b - CNT_W'(over);
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_next[i] = rank_b[i];
                if (over && valid_b[i] && (rank_b[i] == RANK_W'(count_b - 1'b1)))
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (key_we[i])
            begin
                key_reg[i] <= op.lookup_key;
            end
            if (value_we[i])
            begin
                value_reg[i] <= op.write_value;
            end
        end
    end

    `LKC_ASSERT(a_count_valid, clk, rst_n, $countones(valid_reg) == int'(count_reg), "bad count")
    `LKC_ASSERT_NEVER(a_count_in_range, clk, rst_n, count_reg > CNT_FULL, "count above depth")
    `LKC_ASSERT(a_hit_count, clk, rst_n, op_valid && match_hit |=> $stable(count_reg), "hit count")

endmodule

// ===== hw/rtl/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache core
// fully associative key/value store with least recently used replacement
// ----------------------------------------------------------------------------
//
//  channel   handshake                 word
//  -------   -----------------------   ----------------------------------------
//  request   start, busy               request (action, lookup_key, write_value)
//  result    result_valid strobe       result (hit, read_value)
//  config    cfg_valid, cfg_ready      cfg_data (capacity)
//
//  one request per clock, busy never rises
//  result strobe follows start through the request register, then the
//  match/update logic into the result register
//  the receiver cannot stall, every result is shown for exactly one cycle
//  reset clears all entries and sets capacity to 16, no clearing pass
//
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lru_kvc_pkg::req_word_t        request,
    output logic                          result_valid,
    output lru_kvc_pkg::rsp_word_t        result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lru_kvc_pkg::CAP_W-1:0] cfg_data
);
    import lru_kvc_pkg::*;

    logic             req_valid_reg;
    req_word_t        req_reg;
    logic             result_valid_reg;
    rsp_word_t        result_reg;
    logic [CAP_W-1:0] capacity_reg;
    rsp_word_t        table_result;
    logic             put_in_flight;

    // every request finishes in a single pass, so the core is always open
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    // lookup and table update happen in the cycle after capture
    lru_kvc_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (req_valid_reg),
        .op       (req_reg),
        .capacity (capacity_reg),
        .result   (table_result)
    );

    // result register, shown for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            result_reg <= table_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a put word in the update stage
    assign put_in_flight = req_valid_reg && (req_reg.action == ACT_PUT);

    `LKC_ASSERT(a_result_follows, clk, rst_n, req_valid_reg |=> result_valid_reg, "lost result")
    `LKC_ASSERT(a_no_spurious, clk, rst_n, !req_valid_reg |=> !result_valid_reg, "extra result")
    `LKC_ASSERT(a_put_ones, clk, rst_n, put_in_flight |=> &result_reg.read_value, "put data")

endmodule
